FILE: sv/obpc_pkg.sv
// Shared types, widths and codes for the oriented box point classifier.
package obpc_pkg;

    localparam int COORD_W = 32;
    localparam int DIFF_W  = 33;
    localparam int TRIG_W  = 18;
    localparam int ISC_W   = 24;
    localparam int PROD_W  = DIFF_W + TRIG_W;   // 51
    localparam int ROT_W   = PROD_W + 1 - 16;   // 36
    localparam int OBJ_W   = ROT_W + ISC_W + 1; // 61
    localparam int DIST_W  = OBJ_W + 1;         // 62

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_ADDR_W-1:0] REG_CENTER_X    = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_CENTER_Y    = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_CENTER_Z    = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_COS_ROT     = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_SIN_ROT     = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_INV_SCALE_X = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] REG_INV_SCALE_Y = 3'd6;
    localparam logic [CFG_ADDR_W-1:0] REG_INV_SCALE_Z = 3'd7;

    localparam logic [2:0] FACE_TOP    = 3'd0;
    localparam logic [2:0] FACE_BOTTOM = 3'd1;
    localparam logic [2:0] FACE_FRONT  = 3'd2;
    localparam logic [2:0] FACE_BACK   = 3'd3;
    localparam logic [2:0] FACE_RIGHT  = 3'd4;
    localparam logic [2:0] FACE_LEFT   = 3'd5;

    localparam logic signed [TRIG_W-1:0] ONE_Q16     = 18'sd65536;
    localparam logic signed [TRIG_W-1:0] NEG_ONE_Q16 = -18'sd65536;
    localparam logic signed [DIST_W-1:0] HALF_Q32    = 62'sd2147483648;

    typedef struct packed {
        logic signed [COORD_W-1:0] center_x;
        logic signed [COORD_W-1:0] center_y;
        logic signed [COORD_W-1:0] center_z;
        logic signed [TRIG_W-1:0]  cos_rot;
        logic signed [TRIG_W-1:0]  sin_rot;
        logic [ISC_W-1:0]          inv_scale_x;
        logic [ISC_W-1:0]          inv_scale_y;
        logic [ISC_W-1:0]          inv_scale_z;
    } cfg_t;

    typedef struct packed {
        logic [DIST_W-1:0] gap;
        logic [2:0]        face;
    } cand_t;

endpackage

FILE: sv/oriented_box_point_classifier_core.sv
// Top level: configuration registers, stage valid chain and the two datapath halves.
// Seven register stages: four in obpc_xform and three in obpc_face.
// One transaction per cycle is sustained while the output is ready; each stage holds independently on backpressure,
// so empty stages fill while the output waits.
// Reset clears all stage valid bits and loads the configuration register defaults
// (centers 0, cos 1.0, sin 0, inverse scales 1.0); payload registers are not reset.
module oriented_box_point_classifier_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [obpc_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [obpc_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // point_x [31:0], point_y [63:32], point_z [95:64]
    input  logic [95:0]                         s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // inside_res [0], face [3:1], normal_x [21:4], normal_y [39:22],
    // normal_z [57:40], zero fill [63:58]
    output logic [63:0]                         m_axis_tdata
);
    import obpc_pkg::*;

    localparam int NSTAGE = 7;

    cfg_t              cfg_reg;
    logic [NSTAGE-1:0] valid_reg, valid_next;
    logic [NSTAGE:0]   ready;
    logic [NSTAGE-1:0] load;

    logic signed [OBJ_W-1:0]  ox, oy, oz;
    logic                     inside_res;
    logic [2:0]               face;
    logic signed [TRIG_W-1:0] normal_x, normal_y, normal_z;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.center_x    <= '0;
            cfg_reg.center_y    <= '0;
            cfg_reg.center_z    <= '0;
            cfg_reg.cos_rot     <= ONE_Q16;
            cfg_reg.sin_rot     <= '0;
            cfg_reg.inv_scale_x <= ISC_W'(65536);
            cfg_reg.inv_scale_y <= ISC_W'(65536);
            cfg_reg.inv_scale_z <= ISC_W'(65536);
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_CENTER_X:    cfg_reg.center_x    <= cfg_wdata;
                REG_CENTER_Y:    cfg_reg.center_y    <= cfg_wdata;
                REG_CENTER_Z:    cfg_reg.center_z    <= cfg_wdata;
                REG_COS_ROT:     cfg_reg.cos_rot     <= cfg_wdata[TRIG_W-1:0];
                REG_SIN_ROT:     cfg_reg.sin_rot     <= cfg_wdata[TRIG_W-1:0];
                REG_INV_SCALE_X: cfg_reg.inv_scale_x <= cfg_wdata[ISC_W-1:0];
                REG_INV_SCALE_Y: cfg_reg.inv_scale_y <= cfg_wdata[ISC_W-1:0];
                default:         cfg_reg.inv_scale_z <= cfg_wdata[ISC_W-1:0];
            endcase
        end
    end

    // A stage takes new data when it is empty or its own content moves on.
    always_comb
    begin
        ready[NSTAGE] = m_axis_tready;
        for (int k = NSTAGE - 1; k >= 0; k--)
            ready[k] = !valid_reg[k] || ready[k+1];
        load = ready[NSTAGE-1:0];
        valid_next[0] = load[0] ? s_axis_tvalid : valid_reg[0];
        for (int k = 1; k < NSTAGE; k++)
            valid_next[k] = load[k] ? valid_reg[k-1] : valid_reg[k];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= valid_next;
    end

    obpc_xform u_xform (
        .clk     (clk),
        .load    (load[3:0]),
        .cfg     (cfg_reg),
        .point_x (s_axis_tdata[31:0]),
        .point_y (s_axis_tdata[63:32]),
        .point_z (s_axis_tdata[95:64]),
        .ox      (ox),
        .oy      (oy),
        .oz      (oz)
    );

    obpc_face u_face (
        .clk        (clk),
        .load       (load[6:4]),
        .cfg        (cfg_reg),
        .ox         (ox),
        .oy         (oy),
        .oz         (oz),
        .inside_res (inside_res),
        .face       (face),
        .normal_x   (normal_x),
        .normal_y   (normal_y),
        .normal_z   (normal_z)
    );

    assign s_axis_tready = ready[0];
    assign m_axis_tvalid = valid_reg[NSTAGE-1];
    assign m_axis_tdata  = {6'b0, normal_z, normal_y, normal_x, face, inside_res};

endmodule

FILE: sv/obpc_xform.sv
// Four-stage transform of a world point into the box's object space.
module obpc_xform (
    input  logic                                 clk,
    input  logic [3:0]                           load,
    input  obpc_pkg::cfg_t                       cfg,
    input  logic signed [obpc_pkg::COORD_W-1:0]  point_x,
    input  logic signed [obpc_pkg::COORD_W-1:0]  point_y,
    input  logic signed [obpc_pkg::COORD_W-1:0]  point_z,
    output logic signed [obpc_pkg::OBJ_W-1:0]    ox,
    output logic signed [obpc_pkg::OBJ_W-1:0]    oy,
    output logic signed [obpc_pkg::OBJ_W-1:0]    oz
);
    import obpc_pkg::*;

    logic signed [DIFF_W-1:0] dx_reg, dy_reg, dz_reg;
    logic signed [DIFF_W-1:0] dz_s2_reg, dz_s3_reg;
    logic signed [PROD_W-1:0] cdx_reg, sdy_reg, cdy_reg, sdx_reg;
    logic signed [ROT_W-1:0]  rx_reg, ry_reg;
    logic signed [OBJ_W-1:0]  ox_reg, oy_reg, oz_reg;

    logic signed [PROD_W:0]   sum_x, sum_y;
    logic signed [ISC_W:0]    isx, isy, isz;
    logic signed [DIFF_W+ISC_W:0] oz_full;

    assign isx = $signed({1'b0, cfg.inv_scale_x});
    assign isy = $signed({1'b0, cfg.inv_scale_y});
    assign isz = $signed({1'b0, cfg.inv_scale_z});

    // Arithmetic shift by 16 keeps the floor rounding of the rotation.
    assign sum_x = (PROD_W+1)'(cdx_reg) + (PROD_W+1)'(sdy_reg);
    assign sum_y = (PROD_W+1)'(cdy_reg) - (PROD_W+1)'(sdx_reg);
    assign oz_full = dz_s3_reg * isz;

    always_ff @(posedge clk)
    begin
        if (load[0])
        begin
            dx_reg <= DIFF_W'(point_x) - DIFF_W'(cfg.center_x);
            dy_reg <= DIFF_W'(point_y) - DIFF_W'(cfg.center_y);
            dz_reg <= DIFF_W'(point_z) - DIFF_W'(cfg.center_z);
        end
        if (load[1])
        begin
            cdx_reg   <= cfg.cos_rot * dx_reg;
            sdy_reg   <= cfg.sin_rot * dy_reg;
            cdy_reg   <= cfg.cos_rot * dy_reg;
            sdx_reg   <= cfg.sin_rot * dx_reg;
            dz_s2_reg <= dz_reg;
        end
        if (load[2])
        begin
            rx_reg    <= sum_x[PROD_W:16];
            ry_reg    <= sum_y[PROD_W:16];
            dz_s3_reg <= dz_s2_reg;
        end
        if (load[3])
        begin
            ox_reg <= rx_reg * isx;
            oy_reg <= ry_reg * isy;
            oz_reg <= OBJ_W'(oz_full);
        end
    end

    assign ox = ox_reg;
    assign oy = oy_reg;
    assign oz = oz_reg;

endmodule

FILE: sv/obpc_face.sv
// Three-stage inside test, nearest face search and normal selection.
module obpc_face (
    input  logic                                 clk,
    input  logic [2:0]                           load,
    input  obpc_pkg::cfg_t                       cfg,
    input  logic signed [obpc_pkg::OBJ_W-1:0]    ox,
    input  logic signed [obpc_pkg::OBJ_W-1:0]    oy,
    input  logic signed [obpc_pkg::OBJ_W-1:0]    oz,
    output logic                                 inside_res,
    output logic [2:0]                           face,
    output logic signed [obpc_pkg::TRIG_W-1:0]   normal_x,
    output logic signed [obpc_pkg::TRIG_W-1:0]   normal_y,
    output logic signed [obpc_pkg::TRIG_W-1:0]   normal_z
);
    import obpc_pkg::*;

    logic [DIST_W-1:0] dist_reg [6];
    logic              in_s5_reg, in_s6_reg, inside_reg;
    cand_t             pair_reg [3];
    logic [2:0]        face_reg;
    logic signed [TRIG_W-1:0] nx_reg, ny_reg, nz_reg;

    logic signed [DIST_W-1:0] o_ext [3];
    logic [DIST_W-1:0]        dist_next [6];
    logic                     in_next;
    cand_t                    pair_next [3];
    cand_t                    best;
    logic signed [TRIG_W-1:0] nx_next, ny_next, nz_next;

    function automatic logic [DIST_W-1:0] absd(input logic signed [DIST_W-1:0] v);
        absd = v[DIST_W-1] ? DIST_W'(-v) : DIST_W'(v);
    endfunction

    // Axis order in o_ext is y, z, x so that faces come out in their code order.
    assign o_ext[0] = DIST_W'(oy);
    assign o_ext[1] = DIST_W'(oz);
    assign o_ext[2] = DIST_W'(ox);

    always_comb
    begin
        in_next = 1'b1;
        for (int a = 0; a < 3; a++)
        begin
            dist_next[2*a]   = absd(HALF_Q32 - o_ext[a]);
            dist_next[2*a+1] = absd(o_ext[a] + HALF_Q32);
            if (o_ext[a] > HALF_Q32 || o_ext[a] < -HALF_Q32)
                in_next = 1'b0;
        end
    end

    // A later face wins only when strictly closer.
    always_comb
    begin
        for (int p = 0; p < 3; p++)
        begin
            if (dist_reg[2*p+1] < dist_reg[2*p])
                pair_next[p] = '{gap: dist_reg[2*p+1], face: 3'(2*p+1)};
            else
                pair_next[p] = '{gap: dist_reg[2*p], face: 3'(2*p)};
        end
    end

    always_comb
    begin
        best = pair_reg[0];
        if (pair_reg[1].gap < best.gap)
            best = pair_reg[1];
        if (pair_reg[2].gap < best.gap)
            best = pair_reg[2];

        nx_next = '0;
        ny_next = '0;
        nz_next = '0;
        unique case (best.face)
            FACE_TOP:
            begin
                nx_next = -cfg.sin_rot;
                ny_next = cfg.cos_rot;
            end
            FACE_BOTTOM:
            begin
                nx_next = cfg.sin_rot;
                ny_next = -cfg.cos_rot;
            end
            FACE_FRONT:  nz_next = ONE_Q16;
            FACE_BACK:   nz_next = NEG_ONE_Q16;
            FACE_RIGHT:
            begin
                nx_next = cfg.cos_rot;
                ny_next = cfg.sin_rot;
            end
            default:
            begin
                nx_next = -cfg.cos_rot;
                ny_next = -cfg.sin_rot;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (load[0])
        begin
            dist_reg  <= dist_next;
            in_s5_reg <= in_next;
        end
        if (load[1])
        begin
            pair_reg  <= pair_next;
            in_s6_reg <= in_s5_reg;
        end
        if (load[2])
        begin
            inside_reg <= in_s6_reg;
            face_reg   <= best.face;
            nx_reg     <= nx_next;
            ny_reg     <= ny_next;
            nz_reg     <= nz_next;
        end
    end

    assign inside_res = inside_reg;
    assign face       = face_reg;
    assign normal_x   = nx_reg;
    assign normal_y   = ny_reg;
    assign normal_z   = nz_reg;

endmodule
